// ----- rtl/sensor_packet_deframer_tlv_parser_defines.svh -----
// assertion helpers shared by the checker
`ifndef SENSOR_PACKET_DEFRAMER_TLV_PARSER_DEFINES_SVH
`define SENSOR_PACKET_DEFRAMER_TLV_PARSER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SPDTLV_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spdtlv check failed");

// consequent must hold in the cycle after the antecedent
`define SPDTLV_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spdtlv check failed");

`endif

// ----- rtl/spdtlv_pkg.sv -----
package spdtlv_pkg;

   localparam logic [7:0]  PREAMBLE   = 8'hFA;
   localparam logic [7:0]  BUS_ID     = 8'hFF;
   localparam logic [7:0]  MID_DATA   = 8'h36;
   localparam logic [15:0] REC_QUAT   = 16'h2010;
   localparam logic [15:0] REC_ACCEL  = 16'h4020;
   localparam logic [15:0] REC_GYRO   = 16'h8020;
   localparam logic [15:0] REC_COUNT  = 16'h1020;
   localparam int          MAX_FILL   = 16;
   localparam int          QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      KIND_QUAT    = 3'd0,
      KIND_ACCEL   = 3'd1,
      KIND_GYRO    = 3'd2,
      KIND_COUNTER = 3'd3,
      KIND_STATUS  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_BAD_PREAMBLE = 3'd1,
      ST_BAD_BUS_ID   = 3'd2,
      ST_BAD_CHECKSUM = 3'd3,
      ST_OTHER_MSG    = 3'd4,
      ST_TRUNCATED    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      HERR_NONE     = 2'd0,
      HERR_PREAMBLE = 2'd1,
      HERR_BUS_ID   = 2'd2
   } herr_type;

   typedef enum logic [1:0] {
      PH_ID_HI = 2'd0,
      PH_ID_LO = 2'd1,
      PH_LEN   = 2'd2,
      PH_DATA  = 2'd3
   } phase_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] word_c;
      logic [31:0] word_d;
      status_type  frame_status;
      logic        last_result;
   } res_type;

   typedef struct packed {
      logic    rec_valid;
      logic    stat_valid;
      res_type rec;
      res_type stat;
   } push_type;

endpackage

// ----- rtl/spdtlv_ifs.sv -----
interface spdtlv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       end_of_transfer;

   modport source (output valid, output rx_byte, output end_of_transfer, input ready);
   modport sink (input valid, input rx_byte, input end_of_transfer, output ready);
endinterface

interface spdtlv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] word_a;
   logic [31:0] word_b;
   logic [31:0] word_c;
   logic [31:0] word_d;
   logic [2:0]  frame_status;
   logic        last_result;

   modport source (output valid, output kind, output word_a, output word_b, output word_c,
                   output word_d, output frame_status, output last_result, input ready);
   modport sink (input valid, input kind, input word_a, input word_b, input word_c,
                 input word_d, input frame_status, input last_result, output ready);
endinterface

// ----- rtl/spdtlv_parser.sv -----
module spdtlv_parser import spdtlv_pkg::*; #(
   parameter int MAX_TRANSFER = 4096
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] rx_byte,
   input  logic       end_of_transfer,
   output push_type   push
);

   localparam int POS_W = $clog2(MAX_TRANSFER + 1);
   localparam int CMP_W = (POS_W > 9) ? POS_W : 9;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       sum_ff, sum_in;
   herr_type         herr_ff, herr_in;
   logic [7:0]       mid_ff, mid_in;
   logic [7:0]       len_ff, len_in;
   phase_type        phase_ff, phase_in;
   logic [15:0]      rtype_ff, rtype_in;
   logic [7:0]       rem_ff, rem_in;
   logic [31:0]      words_ff [4];
   logic [31:0]      words_in [4];
   logic [7:0]       dcnt_ff, dcnt_in;
   logic [4:0]       fill_ff, fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         sum_ff   <= '0;
         herr_ff  <= HERR_NONE;
         mid_ff   <= '0;
         len_ff   <= '0;
         phase_ff <= PH_ID_HI;
         rtype_ff <= '0;
         rem_ff   <= '0;
         for (int i = 0; i < 4; i++) words_ff[i] <= '0;
         dcnt_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         sum_ff   <= sum_in;
         herr_ff  <= herr_in;
         mid_ff   <= mid_in;
         len_ff   <= len_in;
         phase_ff <= phase_in;
         rtype_ff <= rtype_in;
         rem_ff   <= rem_in;
         for (int i = 0; i < 4; i++) words_ff[i] <= words_in[i];
         dcnt_ff  <= dcnt_in;
         fill_ff  <= fill_in;
      end
   end

   always_comb begin
      logic [7:0]       avail;
      logic [1:0]       lane;
      logic             emit;
      logic [8:0]       need;
      logic             known;
      kind_type         rkind;
      status_type       st;

      pos_in   = pos_ff;
      sum_in   = sum_ff;
      herr_in  = herr_ff;
      mid_in   = mid_ff;
      len_in   = len_ff;
      phase_in = phase_ff;
      rtype_in = rtype_ff;
      rem_in   = rem_ff;
      for (int i = 0; i < 4; i++) words_in[i] = words_ff[i];
      dcnt_in  = dcnt_ff;
      fill_in  = fill_ff;
      avail    = '0;
      lane     = ~fill_ff[1:0];
      emit     = 1'b0;
      need     = 9'd5;
      known    = 1'b1;
      rkind    = KIND_QUAT;
      st       = ST_OK;
      push     = '0;

      // bytes past the transfer limit are dropped
      if (accept && pos_ff < POS_W'(MAX_TRANSFER)) begin
         pos_in = pos_ff + POS_W'(1);
         if (pos_ff != '0) sum_in = sum_ff + rx_byte;
         if (pos_ff == POS_W'(0)) begin
            if (rx_byte != PREAMBLE) herr_in = HERR_PREAMBLE;
         end else if (pos_ff == POS_W'(1)) begin
            if (rx_byte != BUS_ID && herr_ff == HERR_NONE) herr_in = HERR_BUS_ID;
         end else if (pos_ff == POS_W'(2)) begin
            mid_in = rx_byte;
         end else if (pos_ff == POS_W'(3)) begin
            len_in = rx_byte;
         end else if (herr_ff == HERR_NONE && mid_ff == MID_DATA && dcnt_ff < len_ff) begin
            dcnt_in = dcnt_ff + 8'd1;
            case (phase_ff)
               PH_ID_HI: begin
                  rtype_in = {rx_byte, 8'h00};
                  phase_in = PH_ID_LO;
               end
               PH_ID_LO: begin
                  rtype_in = {rtype_ff[15:8], rx_byte};
                  phase_in = PH_LEN;
               end
               PH_LEN: begin
                  avail = len_ff - dcnt_in;
                  for (int i = 0; i < 4; i++) words_in[i] = '0;
                  fill_in = '0;
                  if (rx_byte > avail) begin
                     // record overruns the payload: skip the rest
                     rtype_in = '0;
                     rem_in   = avail;
                     phase_in = (avail == '0) ? PH_ID_HI : PH_DATA;
                  end else begin
                     rem_in = rx_byte;
                     if (rx_byte == '0) begin
                        phase_in = PH_ID_HI;
                        emit     = 1'b1;
                     end else begin
                        phase_in = PH_DATA;
                     end
                  end
               end
               default: begin
                  if (fill_ff < 5'(MAX_FILL)) begin
                     words_in[fill_ff[3:2]][{lane, 3'b000} +: 8] = rx_byte;
                     fill_in = fill_ff + 5'd1;
                  end
                  rem_in = rem_ff - 8'd1;
                  if (rem_in == '0) begin
                     phase_in = PH_ID_HI;
                     emit     = 1'b1;
                  end
               end
            endcase
         end
      end

      case (rtype_in)
         REC_QUAT:  rkind = KIND_QUAT;
         REC_ACCEL: rkind = KIND_ACCEL;
         REC_GYRO:  rkind = KIND_GYRO;
         REC_COUNT: rkind = KIND_COUNTER;
         default:   known = 1'b0;
      endcase
      push.rec_valid         = emit && known;
      push.rec.kind          = rkind;
      push.rec.frame_status  = ST_OK;
      push.rec.last_result   = 1'b0;
      if (rkind == KIND_COUNTER) begin
         push.rec.word_a = {16'h0000, words_in[0][31:16]};
      end else begin
         push.rec.word_a = words_in[0];
         push.rec.word_b = words_in[1];
         push.rec.word_c = words_in[2];
         if (rkind == KIND_QUAT) push.rec.word_d = words_in[3];
      end

      if (accept && end_of_transfer) begin
         if (pos_in >= POS_W'(4)) need = 9'd5 + {1'b0, len_in};
         if (herr_in != HERR_NONE) st = status_type'({1'b0, herr_in});
         else if (CMP_W'(pos_in) < CMP_W'(need)) st = ST_TRUNCATED;
         else if (sum_in != '0) st = ST_BAD_CHECKSUM;
         else if (mid_in != MID_DATA) st = ST_OTHER_MSG;
         else st = ST_OK;
         push.stat_valid        = 1'b1;
         push.stat.kind         = KIND_STATUS;
         push.stat.frame_status = st;
         push.stat.last_result  = 1'b1;

         pos_in   = '0;
         sum_in   = '0;
         herr_in  = HERR_NONE;
         mid_in   = '0;
         len_in   = '0;
         phase_in = PH_ID_HI;
         rtype_in = '0;
         rem_in   = '0;
         for (int i = 0; i < 4; i++) words_in[i] = '0;
         dcnt_in  = '0;
         fill_in  = '0;
      end
   end

endmodule

// ----- rtl/spdtlv_outq.sv -----
module spdtlv_outq import spdtlv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop_ready,
   output res_type  head,
   output logic     head_valid,
   output logic     room
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   res_type          q_ff [QUEUE_DEPTH];
   res_type          q_in [QUEUE_DEPTH];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // entry 0 is the output slot; entries shift down on a pop
   always_comb begin
      logic             pop;
      logic [CNT_W-1:0] c1;
      logic [CNT_W-1:0] npush;
      res_type          first;
      res_type          shifted [QUEUE_DEPTH];

      pop   = (cnt_ff != '0) && pop_ready;
      c1    = cnt_ff - CNT_W'(pop);
      npush = CNT_W'(push.rec_valid) + CNT_W'(push.stat_valid);
      first = push.rec_valid ? push.rec : push.stat;
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) shifted[i] = q_ff[i + 1];
      shifted[QUEUE_DEPTH-1] = q_ff[QUEUE_DEPTH-1];
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (CNT_W'(i) < c1) q_in[i] = pop ? shifted[i] : q_ff[i];
         else if (CNT_W'(i) == c1 && npush != '0) q_in[i] = first;
         else if (CNT_W'(i) == c1 + CNT_W'(1) && npush == CNT_W'(2)) q_in[i] = push.stat;
         else q_in[i] = q_ff[i];
      end
      cnt_in = c1 + npush;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) q_ff[i] <= q_in[i];
   end

   assign head       = q_ff[0];
   assign head_valid = (cnt_ff != '0);
   assign room       = (cnt_ff <= CNT_W'(QUEUE_DEPTH - 2));

endmodule

// ----- rtl/sensor_packet_deframer_tlv_parser.sv -----
// Byte-stream deframer for [FA][FF][MID][LEN][payload][checksum] sensor packets. One byte is
// accepted per clock while req_bus ready is high; the parser state updates in the accepting
// cycle and its results land in a four-entry output queue, whose head is offered on rsp_bus.
// Record results (quaternion, acceleration, gyroscope, packet counter) are cut-through: they
// leave before the checksum is seen, so drop them when the closing frame status is not ok. A
// byte that ends a record and the transfer gives two results; req_bus ready drops while the
// queue holds more than two results. Bytes past MAX_TRANSFER are ignored except for their
// end-of-transfer mark.
module sensor_packet_deframer_tlv_parser import spdtlv_pkg::*; #(
   parameter int MAX_TRANSFER = 4096
) (
   input logic         clock,
   input logic         reset,
   spdtlv_req_if.sink   req_bus,
   spdtlv_rsp_if.source rsp_bus
);

   logic     accept;
   logic     room;
   push_type push;
   res_type  head;
   logic     head_valid;

   assign req_bus.ready = room;
   assign accept        = req_bus.valid && room;

   spdtlv_parser #(
      .MAX_TRANSFER(MAX_TRANSFER)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .rx_byte        (req_bus.rx_byte),
      .end_of_transfer(req_bus.end_of_transfer),
      .push           (push)
   );

   spdtlv_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (rsp_bus.ready),
      .head      (head),
      .head_valid(head_valid),
      .room      (room)
   );

   assign rsp_bus.valid        = head_valid;
   assign rsp_bus.kind         = head.kind;
   assign rsp_bus.word_a       = head.word_a;
   assign rsp_bus.word_b       = head.word_b;
   assign rsp_bus.word_c       = head.word_c;
   assign rsp_bus.word_d       = head.word_d;
   assign rsp_bus.frame_status = head.frame_status;
   assign rsp_bus.last_result  = head.last_result;

endmodule

// ----- rtl/spdtlv_checker.sv -----
`include "sensor_packet_deframer_tlv_parser_defines.svh"

module spdtlv_checker import spdtlv_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [31:0] rsp_word_a,
   input logic [31:0] rsp_word_b,
   input logic [31:0] rsp_word_c,
   input logic [31:0] rsp_word_d,
   input logic [2:0]  rsp_frame_status,
   input logic        rsp_last
);

   // a stalled transaction keeps its payload
   `SPDTLV_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_kind) && $stable(rsp_word_a) && $stable(rsp_last))
   `SPDTLV_ASSERT_NOW(a_last_is_status, rsp_valid && rsp_last, rsp_kind == KIND_STATUS)
   `SPDTLV_ASSERT_NOW(a_record_clean, rsp_valid && rsp_kind != KIND_STATUS, rsp_frame_status == ST_OK && !rsp_last)
   `SPDTLV_ASSERT_NOW(a_status_words, rsp_valid && rsp_kind == KIND_STATUS, rsp_last && rsp_word_a == '0 && rsp_word_b == '0 && rsp_word_c == '0 && rsp_word_d == '0)
   `SPDTLV_ASSERT_NOW(a_counter_words, rsp_valid && rsp_kind == KIND_COUNTER, rsp_word_a[31:16] == '0 && rsp_word_b == '0 && rsp_word_c == '0 && rsp_word_d == '0)

endmodule

bind sensor_packet_deframer_tlv_parser spdtlv_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.kind),
   .rsp_word_a      (rsp_bus.word_a),
   .rsp_word_b      (rsp_bus.word_b),
   .rsp_word_c      (rsp_bus.word_c),
   .rsp_word_d      (rsp_bus.word_d),
   .rsp_frame_status(rsp_bus.frame_status),
   .rsp_last        (rsp_bus.last_result)
);

// ----- sim/deframer_checker.sv -----
`timescale 1ns / 100ps

module deframer_checker import spdtlv_pkg::*; #(
   parameter int MAX_TRANSFER = 4096
) (
   input  logic  clock,
   input  logic  reset,
   spdtlv_req_if req_bus,
   spdtlv_rsp_if rsp_bus,
   output int    mismatch_count,
   output int    pending
);

   // parser state mirrored from the block
   int          byte_pos;
   logic [7:0]  frame_sum;
   herr_type    herr;
   logic [7:0]  msg_id;
   logic [7:0]  pay_len;
   phase_type   phase;
   logic [15:0] rec_id;
   logic [7:0]  rec_left;
   logic [31:0] rec_words [4];
   logic [7:0]  data_cnt;
   int          fill;

   res_type expected_results [$];
   int      errors = 0;
   int      waiting = 0;

   assign mismatch_count = errors;
   assign pending        = waiting;

   task automatic clear_parser();
      byte_pos  = 0;
      frame_sum = 8'h00;
      herr      = HERR_NONE;
      msg_id    = 8'h00;
      pay_len   = 8'h00;
      phase     = PH_ID_HI;
      rec_id    = 16'h0000;
      rec_left  = 8'h00;
      rec_words = '{default: 32'h0};
      data_cnt  = 8'h00;
      fill      = 0;
   endtask

   task automatic push_record();
      res_type r;
      r        = '0;
      r.word_a = rec_words[0];
      r.word_b = rec_words[1];
      r.word_c = rec_words[2];
      r.word_d = rec_words[3];
      case (rec_id)
         REC_QUAT: r.kind = KIND_QUAT;
         REC_ACCEL: begin
            r.kind   = KIND_ACCEL;
            r.word_d = 32'h0;
         end
         REC_GYRO: begin
            r.kind   = KIND_GYRO;
            r.word_d = 32'h0;
         end
         REC_COUNT: begin
            r.kind   = KIND_COUNTER;
            r.word_a = {16'h0000, rec_words[0][31:16]};
            r.word_b = 32'h0;
            r.word_c = 32'h0;
            r.word_d = 32'h0;
         end
         default: return;
      endcase
      r.frame_status = ST_OK;
      r.last_result  = 1'b0;
      expected_results.push_back(r);
   endtask

   task automatic take_payload(input logic [7:0] b);
      logic [7:0] room;
      data_cnt = data_cnt + 8'd1;
      case (phase)
         PH_ID_HI: begin
            rec_id = {b, 8'h00};
            phase  = PH_ID_LO;
         end
         PH_ID_LO: begin
            rec_id[7:0] = b;
            phase       = PH_LEN;
         end
         PH_LEN: begin
            room      = pay_len - data_cnt;
            rec_words = '{default: 32'h0};
            fill      = 0;
            if (b > room) begin
               // record runs past the payload: skip the rest silently
               rec_id   = 16'h0000;
               rec_left = room;
               phase    = (room == 8'h00) ? PH_ID_HI : PH_DATA;
            end else begin
               rec_left = b;
               if (b == 8'h00) begin
                  phase = PH_ID_HI;
                  push_record();
               end else begin
                  phase = PH_DATA;
               end
            end
         end
         default: begin
            if (fill < MAX_FILL) begin
               rec_words[fill / 4][8 * (3 - fill % 4) +: 8] = b;
               fill++;
            end
            rec_left = rec_left - 8'd1;
            if (rec_left == 8'h00) begin
               phase = PH_ID_HI;
               push_record();
            end
         end
      endcase
   endtask

   task automatic deframe_byte(input logic [7:0] b, input logic eot);
      int      p;
      int      need;
      res_type s;
      if (byte_pos < MAX_TRANSFER) begin
         p        = byte_pos;
         byte_pos = byte_pos + 1;
         if (p >= 1) frame_sum = frame_sum + b;
         if (p == 0) begin
            if (b != PREAMBLE) herr = HERR_PREAMBLE;
         end else if (p == 1) begin
            if (b != BUS_ID && herr == HERR_NONE) herr = HERR_BUS_ID;
         end else if (p == 2) begin
            msg_id = b;
         end else if (p == 3) begin
            pay_len = b;
         end else if (herr == HERR_NONE && msg_id == MID_DATA && data_cnt < pay_len) begin
            take_payload(b);
         end
      end
      if (eot) begin
         need          = (byte_pos >= 4) ? 5 + int'(pay_len) : 5;
         s             = '0;
         s.kind        = KIND_STATUS;
         s.last_result = 1'b1;
         if (herr == HERR_PREAMBLE)    s.frame_status = ST_BAD_PREAMBLE;
         else if (herr == HERR_BUS_ID) s.frame_status = ST_BAD_BUS_ID;
         else if (byte_pos < need)     s.frame_status = ST_TRUNCATED;
         else if (frame_sum != 8'h00)  s.frame_status = ST_BAD_CHECKSUM;
         else if (msg_id != MID_DATA)  s.frame_status = ST_OTHER_MSG;
         else                          s.frame_status = ST_OK;
         expected_results.push_back(s);
         clear_parser();
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      res_type e;
      if (expected_results.size() == 0) begin
         $error("kind: expected no transaction, actual %0d", rsp_bus.kind);
         errors++;
      end else begin
         e = expected_results.pop_front();
         compare_field("kind", 32'(e.kind), 32'(rsp_bus.kind));
         compare_field("word_a", e.word_a, rsp_bus.word_a);
         compare_field("word_b", e.word_b, rsp_bus.word_b);
         compare_field("word_c", e.word_c, rsp_bus.word_c);
         compare_field("word_d", e.word_d, rsp_bus.word_d);
         compare_field("frame_status", 32'(e.frame_status), 32'(rsp_bus.frame_status));
         compare_field("last_result", 32'(e.last_result), 32'(rsp_bus.last_result));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parser();
         expected_results.delete();
      end else begin
         // results are registered before they reach rsp_bus, so check before predicting
         if (rsp_bus.valid && rsp_bus.ready) check_result();
         if (req_bus.valid && req_bus.ready)
            deframe_byte(req_bus.rx_byte, req_bus.end_of_transfer);
      end
      waiting <= expected_results.size();
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top import spdtlv_pkg::*;;

   localparam int MAX_TRANSFER = 4096;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 100;
   localparam logic [15:0] REC_IDS [4] = '{REC_QUAT, REC_ACCEL, REC_GYRO, REC_COUNT};

   typedef enum {
      F_GOOD,
      F_PREAMBLE,
      F_BUS_ID,
      F_CHECKSUM,
      F_TRUNCATE,
      F_DROP_LAST,
      F_SHORT_LEN
   } frame_flaw_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatches;
   int   pending;
   int   cycles = 0;
   int   sent = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;

   logic [7:0] payload_bytes [$];
   logic [7:0] packet_bytes [$];

   spdtlv_req_if req_bus ();
   spdtlv_rsp_if rsp_bus ();

   sensor_packet_deframer_tlv_parser #(.MAX_TRANSFER(MAX_TRANSFER)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   deframer_checker #(.MAX_TRANSFER(MAX_TRANSFER)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .mismatch_count (mismatches),
      .pending        (pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic send_byte(input logic [7:0] b, input logic eot);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.rx_byte         <= b;
      req_bus.end_of_transfer <= eot;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
      @(negedge clock);
   endtask

   task automatic put_record(input logic [15:0] id, input int n, input int fill);
      payload_bytes.push_back(id[15:8]);
      payload_bytes.push_back(id[7:0]);
      payload_bytes.push_back(8'(n));
      repeat (n) payload_bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
   endtask

   task automatic send_frame(input logic [7:0] msg, input frame_flaw_type flaw);
      int         plen;
      logic [7:0] sum;
      packet_bytes.delete();
      packet_bytes.push_back(PREAMBLE);
      packet_bytes.push_back(BUS_ID);
      packet_bytes.push_back(msg);
      plen = payload_bytes.size();
      // declared length shorter than the records: cuts a record or its header
      if (flaw == F_SHORT_LEN && plen > 0) plen = $urandom_range(0, plen - 1);
      packet_bytes.push_back(8'(plen));
      foreach (payload_bytes[i]) packet_bytes.push_back(payload_bytes[i]);
      sum = 8'h00;
      for (int i = 1; i < packet_bytes.size(); i++) sum = sum + packet_bytes[i];
      packet_bytes.push_back(8'h00 - sum);
      case (flaw)
         F_PREAMBLE:  packet_bytes[0] = PREAMBLE ^ 8'($urandom_range(1, 255));
         F_BUS_ID:    packet_bytes[1] = BUS_ID ^ 8'($urandom_range(1, 255));
         F_CHECKSUM:  packet_bytes[packet_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
         F_DROP_LAST: void'(packet_bytes.pop_back());
         F_TRUNCATE: begin
            plen = $urandom_range(1, packet_bytes.size() - 1);
            while (packet_bytes.size() > plen) void'(packet_bytes.pop_back());
         end
         default: ;
      endcase
      foreach (packet_bytes[i]) send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
      payload_bytes.delete();
   endtask

   task automatic send_noise(input int n);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1);
   endtask

   task automatic random_frame();
      int             pick;
      int             nrec;
      logic [7:0]     msg;
      frame_flaw_type flaw;
      nrec = $urandom_range(0, 4);
      repeat (nrec) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0, 1: put_record(REC_QUAT, 16, -1);
            2, 3: put_record(REC_ACCEL, 12, -1);
            4:    put_record(REC_GYRO, 12, -1);
            5, 6: put_record(REC_COUNT, 2, -1);
            7, 8: put_record(REC_IDS[$urandom_range(0, 3)], $urandom_range(0, 20), -1);
            default: put_record(16'($urandom_range(65535)), $urandom_range(0, 8), -1);
         endcase
      end
      msg  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(255)) : MID_DATA;
      pick = $urandom_range(0, 99);
      if (pick < 55)      flaw = F_GOOD;
      else if (pick < 61) flaw = F_PREAMBLE;
      else if (pick < 67) flaw = F_BUS_ID;
      else if (pick < 76) flaw = F_CHECKSUM;
      else if (pick < 84) flaw = F_TRUNCATE;
      else if (pick < 90) flaw = F_DROP_LAST;
      else                flaw = F_SHORT_LEN;
      send_frame(msg, flaw);
   endtask

   task automatic directed_frames();
      // every record kind, with all-ones, all-zeros or random data
      put_record(REC_QUAT, 16, 8'hFF);
      put_record(REC_ACCEL, 12, 8'h00);
      put_record(REC_GYRO, 12, -1);
      put_record(REC_COUNT, 2, 8'hFF);
      send_frame(MID_DATA, F_GOOD);
      // empty, short, long and unknown records
      put_record(REC_QUAT, 0, -1);
      put_record(REC_ACCEL, 5, -1);
      put_record(REC_QUAT, 20, -1);
      put_record(16'h1234, 3, -1);
      put_record(REC_COUNT, 3, -1);
      send_frame(MID_DATA, F_GOOD);
      send_frame(MID_DATA, F_GOOD);
      // record completes on the byte that ends the transfer
      put_record(REC_COUNT, 2, -1);
      send_frame(MID_DATA, F_DROP_LAST);
      put_record(REC_QUAT, 16, -1);
      send_frame(MID_DATA, F_PREAMBLE);
      put_record(REC_GYRO, 12, -1);
      send_frame(MID_DATA, F_BUS_ID);
      put_record(REC_ACCEL, 12, -1);
      send_frame(MID_DATA, F_CHECKSUM);
      put_record(REC_ACCEL, 12, -1);
      send_frame(8'h10, F_GOOD);
      put_record(REC_QUAT, 16, -1);
      send_frame(MID_DATA, F_TRUNCATE);
      put_record(REC_ACCEL, 12, -1);
      put_record(REC_QUAT, 16, -1);
      send_frame(MID_DATA, F_SHORT_LEN);
      // transfers too short to carry a length
      send_byte(PREAMBLE, 1'b1);
      send_byte(PREAMBLE, 1'b0);
      send_byte(BUS_ID, 1'b1);
   endtask

   initial begin
      int phase_end;
      req_bus.valid           = 1'b0;
      req_bus.rx_byte         = 8'h00;
      req_bus.end_of_transfer = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 61;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 61;
            end
            default: begin
               idle_pct  = 35;
               stall_pct = 35;
            end
         endcase
         if (ph == 0) directed_frames();
         phase_end = sent + PHASE_ITEMS;
         while (sent < phase_end) begin
            if ($urandom_range(0, 11) == 0) send_noise($urandom_range(1, 12));
            else random_frame();
         end
      end
      req_bus.valid <= 1'b0;
      wait (pending == 0);
      repeat (24) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ----- sensor_packet_deframer_tlv_parser.f -----
+incdir+rtl
rtl/spdtlv_pkg.sv
rtl/spdtlv_ifs.sv
rtl/spdtlv_parser.sv
rtl/spdtlv_outq.sv
rtl/sensor_packet_deframer_tlv_parser.sv
rtl/spdtlv_checker.sv
sim/deframer_checker.sv
sim/tb_top.sv
